FILE: sv/mbc1_pkg.sv
// mbc1_pkg: shared types and constants of the MBC1-style bank controller
// no dependencies; imported by mbc1_bank_controller
package mbc1_pkg;

  localparam int unsigned RAM_BANK_BYTES = 8192;
  localparam int unsigned ROM_BANK_BYTES = 16384;
  localparam int unsigned BANK_OFS_W     = $clog2(RAM_BANK_BYTES);
  localparam int unsigned ROM_OFS_W      = $clog2(ROM_BANK_BYTES);

  // bus access kinds
  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // configuration register indexes
  localparam logic [1:0] CFG_ROM_BANKS = 2'd0;
  localparam logic [1:0] CFG_RAM_BANKS = 2'd1;
  localparam logic [1:0] CFG_BATTERY   = 2'd2;

  // address regions, top three address bits
  localparam logic [2:0] REGION_RAM_EN   = 3'd0;
  localparam logic [2:0] REGION_ROM_BANK = 3'd1;
  localparam logic [2:0] REGION_RAM_BANK = 3'd2;
  localparam logic [2:0] REGION_MODE     = 3'd3;
  localparam logic [2:0] REGION_RAM      = 3'd5;

  localparam logic [3:0] RAM_EN_KEY = 4'hA;
  localparam logic [7:0] OPEN_BUS   = 8'hFF;

  // remainder unit: one dividend bit per step
  localparam int unsigned DIV_STEPS = 5;

  typedef enum logic [1:0] {
    SRC_OPEN  = 2'd0,
    SRC_ROM   = 2'd1,
    SRC_RAM   = 2'd2,
    SRC_WRITE = 2'd3
  } src_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RAM_RD,
    ST_DIV
  } state_e;

  typedef struct packed {
    logic        operation;
    logic [15:0] address;
    logic [7:0]  write_data;
  } req_t;

  typedef struct packed {
    src_e        source;
    logic [7:0]  read_data;
    logic [18:0] rom_address;
    logic        save_request;
  } rsp_t;

  // value modulo a bank count of 1 to 4
  function automatic logic [1:0] bank_mod(logic [1:0] v, logic [2:0] n);
    logic [1:0] r;
    unique case (n)
      3'd1:    r = 2'd0;
      3'd2:    r = {1'b0, v[0]};
      3'd3:    r = (v == 2'd3) ? 2'd0 : v;
      default: r = v;
    endcase
    return r;
  endfunction

endpackage

FILE: sv/mbc1_ram.sv
// mbc1_ram: generic single-port synchronous RAM with registered read
// no dependencies
module mbc1_ram #(
  parameter int unsigned WIDTH  = 8,
  parameter int unsigned DEPTH  = 32768,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] addr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/mbc1_bank_controller.sv
// mbc1_bank_controller: MBC1-style cartridge bank controller, top level
// depends on mbc1_pkg and mbc1_ram
//
// One request is one CPU bus access; every request gives exactly one response.
// Register writes, ROM reads, open-bus reads and RAM writes load their response
// as they are accepted. RAM reads wait in ST_RAM_RD for the registered read of
// the banked RAM. A ROM bank write while rom_count_q is nonzero waits in ST_DIV: the
// bank number is reduced modulo the count by a remainder unit that handles one
// dividend bit per cycle over five steps. After reset the banked RAM is
// cleared to zero by a sweep of all RAM_BANKS * 8192 bytes, one byte a cycle;
// no request is taken during the sweep, configuration writes are. The
// response register lets a new request in while the previous response is
// still stalled on the output only if the output drains in that same cycle.
module mbc1_bank_controller #(
  parameter int unsigned RAM_BANKS = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  // bus access requests
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  mbc1_pkg::req_t in_data_i,
  // responses
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output mbc1_pkg::rsp_t out_data_o,
  // configuration writes
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [1:0]    cfg_index_i,
  input  logic [7:0]    cfg_data_i
);

  import mbc1_pkg::*;

  localparam int unsigned RamDepth = RAM_BANKS * RAM_BANK_BYTES;
  localparam int unsigned RamAw    = $clog2(RamDepth);
  localparam int unsigned CntW     = $clog2(DIV_STEPS);

  // configuration registers
  logic [7:0] rom_count_q;
  logic [2:0] ram_count_q;
  logic       battery_q;

  // controller state
  state_e     state_q, state_d;
  logic       ram_enable_q, ram_enable_d;
  logic [6:0] mapped_q, mapped_d;
  logic [1:0] bank_num_q, bank_num_d;
  logic       mode_q, mode_d;
  logic [1:0] active_q, active_d;
  logic       save_pending_q, save_pending_d;

  // clearing sweep
  logic [RamAw-1:0] clr_addr_q, clr_addr_d;

  // remainder unit
  logic [4:0]      div_num_q, div_num_d;
  logic [4:0]      div_rem_q, div_rem_d;
  logic [CntW-1:0] div_cnt_q, div_cnt_d;
  logic [5:0]      div_trial;
  logic [4:0]      div_rem_next;
  logic [4:0]      bank_sel;

  // response register
  logic out_valid_q, out_valid_d;
  rsp_t out_q, out_d;
  logic out_load;
  rsp_t res;

  // memory port
  logic             ram_we;
  logic [RamAw-1:0] ram_addr;
  logic [7:0]       ram_wdata;
  logic [7:0]       ram_rdata;

  logic             in_acc;
  logic [2:0]       n_banks;
  logic             ram_hit;
  logic [RamAw-1:0] ram_off;
  logic [2:0]       region;

  mbc1_ram #(
    .WIDTH (8),
    .DEPTH (RamDepth),
    .ADDR_W(RamAw)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  // configuration is taken at any time
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rom_count_q <= 8'd2;
      ram_count_q <= 3'd0;
      battery_q   <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_ROM_BANKS: rom_count_q <= cfg_data_i;
        CFG_RAM_BANKS: ram_count_q <= cfg_data_i[2:0];
        CFG_BATTERY:   battery_q   <= cfg_data_i[0];
        default:       ;
      endcase
    end
  end

  // ram banks actually present, count clipped to the built memory
  assign n_banks = (ram_count_q > 3'(RAM_BANKS)) ? 3'(RAM_BANKS) : ram_count_q;

  assign region  = in_data_i.address[15:13];
  assign ram_hit = ram_enable_q && (n_banks != 3'd0) && (region == REGION_RAM);
  assign ram_off = RamAw'({bank_mod(active_q, n_banks),
                           in_data_i.address[BANK_OFS_W-1:0]});

  // a request enters only when idle and the response register frees up
  assign in_stall_o = !((state_q == ST_IDLE) && (!out_valid_q || !out_stall_i));
  assign in_acc     = in_valid_i && !in_stall_o;

  // written bank number, zero taken as one
  assign bank_sel = (in_data_i.write_data[4:0] == 5'd0) ? 5'd1
                                                        : in_data_i.write_data[4:0];

  // restoring remainder step
  assign div_trial    = {div_rem_q, div_num_q[4]};
  assign div_rem_next = ({2'b00, div_trial} >= rom_count_q)
                        ? 5'(div_trial - rom_count_q[5:0]) : div_trial[4:0];

  always_comb begin
    state_d        = state_q;
    ram_enable_d   = ram_enable_q;
    mapped_d       = mapped_q;
    bank_num_d     = bank_num_q;
    mode_d         = mode_q;
    active_d       = active_q;
    save_pending_d = save_pending_q;
    clr_addr_d     = clr_addr_q;
    div_num_d      = div_num_q;
    div_rem_d      = div_rem_q;
    div_cnt_d      = div_cnt_q;
    ram_we         = 1'b0;
    ram_addr       = ram_off;
    ram_wdata      = in_data_i.write_data;
    out_load       = 1'b0;
    res.source       = SRC_WRITE;
    res.read_data    = 8'd0;
    res.rom_address  = 19'd0;
    res.save_request = 1'b0;

    unique case (state_q)
      ST_CLEAR: begin
        ram_we     = 1'b1;
        ram_addr   = clr_addr_q;
        ram_wdata  = 8'd0;
        clr_addr_d = clr_addr_q + RamAw'(1);
        if (clr_addr_q == RamAw'(RamDepth - 1)) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_acc) begin
          if (in_data_i.operation == OP_READ) begin
            if (!in_data_i.address[15]) begin
              // fixed bank 0 below 0x4000, switchable bank above
              res.source      = SRC_ROM;
              res.rom_address = {in_data_i.address[14] ? mapped_q[4:0] : 5'd0,
                                 in_data_i.address[ROM_OFS_W-1:0]};
              out_load        = 1'b1;
            end else if (ram_hit) begin
              state_d = ST_RAM_RD;
            end else begin
              res.source    = SRC_OPEN;
              res.read_data = OPEN_BUS;
              out_load      = 1'b1;
            end
          end else begin
            out_load = 1'b1;
            unique case (region)
              REGION_RAM_EN: begin
                ram_enable_d = (in_data_i.write_data[3:0] == RAM_EN_KEY);
              end
              REGION_ROM_BANK: begin
                if (rom_count_q == 8'd0) begin
                  mapped_d = {2'b00, bank_sel};
                end else begin
                  // response goes out when the remainder is done
                  out_load  = 1'b0;
                  div_num_d = bank_sel;
                  div_rem_d = 5'd0;
                  div_cnt_d = CntW'(DIV_STEPS - 1);
                  state_d   = ST_DIV;
                end
              end
              REGION_RAM_BANK: begin
                bank_num_d = in_data_i.write_data[1:0];
                if (mode_q && (n_banks != 3'd0)) begin
                  res.save_request = save_pending_q;
                  save_pending_d   = 1'b0;
                  active_d         = bank_mod(in_data_i.write_data[1:0], n_banks);
                end
              end
              REGION_MODE: begin
                mode_d = in_data_i.write_data[0];
                if (in_data_i.write_data[0] && (n_banks != 3'd0)) begin
                  res.save_request = save_pending_q;
                  save_pending_d   = 1'b0;
                  active_d         = bank_mod(bank_num_q, n_banks);
                end
              end
              default: begin
                if (ram_hit) begin
                  ram_we = 1'b1;
                  if (battery_q) begin
                    save_pending_d = 1'b1;
                  end
                end
              end
            endcase
          end
        end
      end

      ST_RAM_RD: begin
        res.source    = SRC_RAM;
        res.read_data = ram_rdata;
        out_load      = 1'b1;
        state_d       = ST_IDLE;
      end

      ST_DIV: begin
        div_rem_d = div_rem_next;
        div_num_d = {div_num_q[3:0], 1'b0};
        div_cnt_d = div_cnt_q - CntW'(1);
        if (div_cnt_q == CntW'(0)) begin
          mapped_d = {2'b00, div_rem_next};
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // response register
  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_d       = res;
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_CLEAR;
      ram_enable_q   <= 1'b0;
      mapped_q       <= 7'd1;
      bank_num_q     <= 2'd0;
      mode_q         <= 1'b0;
      active_q       <= 2'd0;
      save_pending_q <= 1'b0;
      clr_addr_q     <= '0;
      div_cnt_q      <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q        <= state_d;
      ram_enable_q   <= ram_enable_d;
      mapped_q       <= mapped_d;
      bank_num_q     <= bank_num_d;
      mode_q         <= mode_d;
      active_q       <= active_d;
      save_pending_q <= save_pending_d;
      clr_addr_q     <= clr_addr_d;
      div_cnt_q      <= div_cnt_d;
      out_valid_q    <= out_valid_d;
    end
  end

  // datapath registers, no reset
  always_ff @(posedge clk_i) begin
    div_num_q <= div_num_d;
    div_rem_q <= div_rem_d;
    out_q     <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  // memory data must find the response register empty
  a_rd_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_RAM_RD |-> !out_valid_q)
    else $error("ram read completes onto a full response register");

  // no response may appear before the clearing sweep ends
  a_clear_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CLEAR |-> !out_valid_q)
    else $error("response during clearing sweep");

  // the remainder unit is to run only with a nonzero modulus; the block does not hold off a zero count
  a_div_modulus: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV |-> rom_count_q != 8'd0)
    else $error("bank reduction with zero rom bank count");

  // save requests come only with write responses
  a_save_on_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.save_request |-> out_q.source == SRC_WRITE)
    else $error("save request on a read response");

  // rom address is zero unless the response is a rom fetch
  a_rom_addr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_q.source != SRC_ROM) |-> out_q.rom_address == 19'd0)
    else $error("rom address set on a non-rom response");
`endif

endmodule

FILE: tb/sv/mbc1_bank_controller_test.sv
// mbc1_bank_controller_test: self-checking bench for the MBC1-style bank controller
// depends on mbc1_pkg and the mbc1_bank_controller RTL; a directed table, then
// random bus traffic under several bank-count settings, all checked per field
module mbc1_bank_controller_test;
  timeunit 1ns;
  timeprecision 1ps;

  import mbc1_pkg::*;

  localparam int unsigned RAM_BANKS      = 4;
  localparam int unsigned RAM_BYTES      = RAM_BANKS * RAM_BANK_BYTES;
  // post-reset clear sweep of all RAM_BANKS * 8192 bytes stalls requests, so leave a wide margin
  localparam int unsigned QUIET_LIMIT    = 150000;
  localparam int unsigned ACCESSES_PER_SETTING = 125;
  localparam int unsigned SETTLE_CYCLES  = 12;
  localparam int unsigned NUM_SETTINGS   = 7;
  // setting in which neither side ever idles
  localparam int unsigned STEADY_SETTING = 3;

  // cartridge settings walked by the random part, extremes and out-of-range counts included
  localparam logic [0:NUM_SETTINGS-1][7:0] ROM_COUNTS =
    {8'd2, 8'd128, 8'd0, 8'd1, 8'd255, 8'd5, 8'd32};
  localparam logic [0:NUM_SETTINGS-1][7:0] RAM_COUNTS =
    {8'd0, 8'd4, 8'd3, 8'd1, 8'd7, 8'd2, 8'd4};
  localparam logic [0:NUM_SETTINGS-1]      BATTERY    = 7'b0110110;

  typedef struct packed {
    req_t access;
    bit   typed;
    rsp_t reply;
  } table_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  req_t in_data;
  logic out_valid;
  logic out_stall = 1'b0;
  rsp_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [1:0] cfg_index;
  logic [7:0] cfg_data;

  // shadow of the controller state, updated as each request is accepted
  logic [7:0] rom_count;
  logic [2:0] ram_count;
  logic       battery;
  logic       ram_en;
  logic [6:0] rom_bank;
  logic [1:0] bank_num;
  logic       mode;
  logic [1:0] act_bank;
  logic       dirty;
  logic [7:0] ram_image [RAM_BYTES];

  rsp_t       replies_due [$];
  table_row_t access_table [$];

  bit          steady;
  int unsigned quiet_cycles = 0;
  int unsigned accesses_sent;
  int unsigned replies_seen = 0;
  int unsigned ram_hits = 0;
  int unsigned saves_seen = 0;
  int unsigned mismatches = 0;

  mbc1_bank_controller #(
    .RAM_BANKS(RAM_BANKS)
  ) DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------------------
  // reply calculation
  // ---------------------------------------------------------------------------

  // bank switch: latch the bank number into the active bank, flush the dirty flag
  function automatic logic switch_ram_bank(int unsigned banks);
    logic save;
    save = 1'b0;
    if (banks != 0) begin
      save     = dirty;
      dirty    = 1'b0;
      act_bank = 2'(32'(bank_num) % banks);
    end
    return save;
  endfunction

  function automatic rsp_t cartridge_reply(req_t rq);
    rsp_t        r;
    int unsigned banks;
    int unsigned bank;
    int unsigned ofs;
    logic        ram_hit;
    r.source       = SRC_WRITE;
    r.read_data    = 8'h00;
    r.rom_address  = '0;
    r.save_request = 1'b0;
    // counts above the physical bank count saturate
    banks   = (32'(ram_count) > RAM_BANKS) ? RAM_BANKS : 32'(ram_count);
    ram_hit = ram_en && banks != 0 && rq.address[15:13] == REGION_RAM;
    ofs     = 0;
    if (banks != 0) begin
      // the active bank may exceed a count that shrank after the switch
      bank = 32'(act_bank) % banks;
      ofs  = bank * RAM_BANK_BYTES + 32'(rq.address[12:0]);
    end
    if (rq.operation == OP_READ) begin
      if (!rq.address[15]) begin
        r.source = SRC_ROM;
        if (rq.address[14]) begin
          r.rom_address = 19'(32'(rom_bank) * ROM_BANK_BYTES + 32'(rq.address[13:0]));
        end else begin
          r.rom_address = 19'(rq.address);
        end
      end else if (ram_hit) begin
        r.source    = SRC_RAM;
        r.read_data = ram_image[ofs];
      end else begin
        r.source    = SRC_OPEN;
        r.read_data = OPEN_BUS;
      end
    end else begin
      case (rq.address[15:13])
        REGION_RAM_EN: begin
          ram_en = (rq.write_data[3:0] == RAM_EN_KEY);
        end
        REGION_ROM_BANK: begin
          bank = 32'(rq.write_data[4:0]);
          if (bank == 0) bank = 1;
          // a zero count keeps the 5-bit bank unreduced; a reduced bank may be 0
          if (rom_count != 8'd0) bank = bank % 32'(rom_count);
          rom_bank = 7'(bank);
        end
        REGION_RAM_BANK: begin
          bank_num = rq.write_data[1:0];
          if (mode) r.save_request = switch_ram_bank(banks);
        end
        REGION_MODE: begin
          mode = rq.write_data[0];
          if (mode) r.save_request = switch_ram_bank(banks);
        end
        default: begin
          if (ram_hit) begin
            ram_image[ofs] = rq.write_data;
            if (battery) dirty = 1'b1;
          end
        end
      endcase
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // random traffic: mostly well-formed register and RAM sequences, some noise
  // ---------------------------------------------------------------------------
  function automatic req_t random_access();
    req_t        rq;
    int unsigned pick;
    rq.operation  = 1'($urandom_range(1));
    rq.address    = 16'($urandom);
    rq.write_data = 8'($urandom);
    pick          = $urandom_range(99);
    if (pick < 30) begin
      // RAM window; offsets cluster so that reads find earlier writes
      rq.address[15:13] = REGION_RAM;
      if ($urandom_range(3) != 0) rq.address[12:0] = 13'($urandom_range(15));
    end else if (pick < 40) begin
      rq.operation      = OP_WRITE;
      rq.address[15:13] = REGION_RAM_EN;
      if ($urandom_range(4) != 0) rq.write_data[3:0] = RAM_EN_KEY;
    end else if (pick < 50) begin
      rq.operation      = OP_WRITE;
      rq.address[15:13] = REGION_ROM_BANK;
    end else if (pick < 60) begin
      rq.operation      = OP_WRITE;
      rq.address[15:13] = REGION_RAM_BANK;
    end else if (pick < 68) begin
      rq.operation      = OP_WRITE;
      rq.address[15:13] = REGION_MODE;
    end else if (pick < 88) begin
      rq.operation   = OP_READ;
      rq.address[15] = 1'b0;
    end
    // remaining picks stay fully random
    return rq;
  endfunction

  // ---------------------------------------------------------------------------
  // request side
  // ---------------------------------------------------------------------------

  // present one request, idling first now and then; the reply is worked out on acceptance
  task automatic send_access(req_t rq, bit typed, rsp_t typed_reply);
    rsp_t calc;
    @(negedge clk);
    while (!steady && $urandom_range(99) < 10) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = rq;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    calc = cartridge_reply(rq);
    replies_due.push_back(typed ? typed_reply : calc);
    accesses_sent++;
  endtask

  task automatic drain_replies();
    @(negedge clk);
    in_valid = 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(logic [1:0] index, logic [7:0] value);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = index;
    cfg_data  = value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (index)
      CFG_ROM_BANKS: rom_count = value;
      CFG_RAM_BANKS: ram_count = value[2:0];
      CFG_BATTERY:   battery   = value[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic add_row(logic op, logic [15:0] addr, logic [7:0] wdata, bit typed,
                         src_e src, logic [7:0] rdata, logic [18:0] raddr);
    table_row_t row;
    row.access.operation  = op;
    row.access.address    = addr;
    row.access.write_data = wdata;
    row.typed             = typed;
    row.reply.source       = src;
    row.reply.read_data    = rdata;
    row.reply.rom_address  = raddr;
    row.reply.save_request = 1'b0;
    access_table.push_back(row);
  endtask

  // ---------------------------------------------------------------------------
  // reply side: random stall, per-field comparison with the oldest reply due
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    out_stall <= !steady && ($urandom_range(99) < 10);
  end

  task automatic check_reply(rsp_t got);
    rsp_t want;
    if (replies_due.size() == 0) begin
      $error("reply with no request outstanding: %h", got);
      mismatches++;
    end else begin
      want = replies_due.pop_front();
      replies_seen++;
      if (got.source == SRC_RAM) ram_hits++;
      if (got.save_request) saves_seen++;
      if (got.source !== want.source) begin
        $error("source: expected %0d, got %0d", want.source, got.source);
        mismatches++;
      end
      if (got.read_data !== want.read_data) begin
        $error("read_data: expected %h, got %h", want.read_data, got.read_data);
        mismatches++;
      end
      if (got.rom_address !== want.rom_address) begin
        $error("rom_address: expected %h, got %h", want.rom_address, got.rom_address);
        mismatches++;
      end
      if (got.save_request !== want.save_request) begin
        $error("save_request: expected %b, got %b", want.save_request, got.save_request);
        mismatches++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) check_reply(out_data);
  end

  // watchdog: cycles in which no channel moves anything
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("mbc1_bank_controller verification failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    cfg_valid    = 1'b0;
    cfg_index    = CFG_ROM_BANKS;
    cfg_data     = 8'h00;
    steady       = 1'b0;
    accesses_sent = 0;
    // reset state of the shadow
    rom_count = 8'd2;
    ram_count = 3'd0;
    battery   = 1'b0;
    ram_en    = 1'b0;
    rom_bank  = 7'd1;
    bank_num  = 2'd0;
    mode      = 1'b0;
    act_bank  = 2'd0;
    dirty     = 1'b0;
    foreach (ram_image[i]) ram_image[i] = 8'h00;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed part: 8 ROM banks, 4 battery-backed RAM banks; the registers are
    // taken during the clear sweep, requests wait for it to finish
    write_register(CFG_ROM_BANKS, 8'd8);
    write_register(CFG_RAM_BANKS, 8'd4);
    write_register(CFG_BATTERY, 8'd1);

    // fixed bank 0 edges and switchable bank at its reset value of 1
    add_row(OP_READ,  16'h3FFF, 8'h5A, 1'b1, SRC_ROM,   8'h00, 19'h03FFF);
    add_row(OP_READ,  16'h4000, 8'h00, 1'b1, SRC_ROM,   8'h00, 19'h04000);
    add_row(OP_READ,  16'h7FFF, 8'hFF, 1'b1, SRC_ROM,   8'h00, 19'h07FFF);
    // RAM still disabled: reads float, writes are dropped
    add_row(OP_READ,  16'hA000, 8'h00, 1'b1, SRC_OPEN,  8'hFF, 19'h0);
    add_row(OP_WRITE, 16'hA000, 8'h55, 1'b1, SRC_WRITE, 8'h00, 19'h0);
    add_row(OP_READ,  16'hFFFF, 8'h00, 1'b1, SRC_OPEN,  8'hFF, 19'h0);
    // enable, then RAM comes up cleared and the dropped write left no trace
    add_row(OP_WRITE, 16'h0000, 8'h0A, 1'b1, SRC_WRITE, 8'h00, 19'h0);
    add_row(OP_READ,  16'hA000, 8'h00, 1'b1, SRC_RAM,   8'h00, 19'h0);
    add_row(OP_WRITE, 16'hBFFF, 8'hFF, 1'b1, SRC_WRITE, 8'h00, 19'h0);
    add_row(OP_READ,  16'hBFFF, 8'h00, 1'b1, SRC_RAM,   8'hFF, 19'h0);
    // bank 0 written becomes 1; all-ones bank wraps modulo the count
    add_row(OP_WRITE, 16'h2000, 8'h00, 1'b0, SRC_WRITE, 8'h00, 19'h0);
    add_row(OP_READ,  16'h4000, 8'h00, 1'b0, SRC_WRITE, 8'h00, 19'h0);
    add_row(OP_WRITE, 16'h3FFF, 8'hFF, 1'b0, SRC_WRITE, 8'h00, 19'h0);
    add_row(OP_READ,  16'h7FFF, 8'h00, 1'b0, SRC_WRITE, 8'h00, 19'h0);
    // bank number in mode 0 does not switch; mode 1 switches and flushes the dirty RAM
    add_row(OP_WRITE, 16'h4000, 8'h03, 1'b0, SRC_WRITE, 8'h00, 19'h0);
    add_row(OP_WRITE, 16'h6000, 8'h01, 1'b0, SRC_WRITE, 8'h00, 19'h0);
    add_row(OP_WRITE, 16'hA123, 8'hA5, 1'b0, SRC_WRITE, 8'h00, 19'h0);
    add_row(OP_WRITE, 16'h5FFF, 8'hFE, 1'b0, SRC_WRITE, 8'h00, 19'h0);
    add_row(OP_READ,  16'hA123, 8'h00, 1'b0, SRC_WRITE, 8'h00, 19'h0);
    // mode cleared keeps the active bank
    add_row(OP_WRITE, 16'h7FFF, 8'h00, 1'b0, SRC_WRITE, 8'h00, 19'h0);
    add_row(OP_WRITE, 16'h4000, 8'h01, 1'b0, SRC_WRITE, 8'h00, 19'h0);
    add_row(OP_READ,  16'hA123, 8'h00, 1'b0, SRC_WRITE, 8'h00, 19'h0);
    // disable with a wrong key, and the inert regions
    add_row(OP_WRITE, 16'h1FFF, 8'hF0, 1'b1, SRC_WRITE, 8'h00, 19'h0);
    add_row(OP_READ,  16'hA000, 8'h00, 1'b1, SRC_OPEN,  8'hFF, 19'h0);
    add_row(OP_WRITE, 16'hC000, 8'h12, 1'b1, SRC_WRITE, 8'h00, 19'h0);
    add_row(OP_READ,  16'h9FFF, 8'h00, 1'b1, SRC_OPEN,  8'hFF, 19'h0);

    foreach (access_table[i]) begin
      send_access(access_table[i].access, access_table[i].typed, access_table[i].reply);
    end
    drain_replies();

    // random part, one batch per cartridge setting, registers changed only when idle
    for (int s = 0; s < NUM_SETTINGS; s++) begin
      steady = (s == STEADY_SETTING);
      write_register(CFG_ROM_BANKS, ROM_COUNTS[s]);
      write_register(CFG_RAM_BANKS, RAM_COUNTS[s]);
      write_register(CFG_BATTERY, {7'd0, BATTERY[s]});
      repeat (ACCESSES_PER_SETTING) send_access(random_access(), 1'b0, '0);
      drain_replies();
    end
    steady = 1'b0;

    // nothing due; let any late extra reply show up
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("ran %0d bus accesses under %0d cartridge settings, %0d replies compared",
             accesses_sent, NUM_SETTINGS + 1, replies_seen);
    $display("%0d banked RAM reads returned data, %0d save requests raised, %0d mismatches",
             ram_hits, saves_seen, mismatches);
    if (mismatches == 0 && replies_due.size() == 0) begin
      $display("mbc1_bank_controller verification clean");
    end else begin
      $display("mbc1_bank_controller verification failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/mbc1_pkg.sv
sv/mbc1_ram.sv
sv/mbc1_bank_controller.sv
tb/sv/mbc1_bank_controller_test.sv
